>>> src/assert_macros.svh
// assertion helpers used by the top-level rtl file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CDD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cdd assertion failed");

// property checked on every rising edge, reset included
`define CDD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cdd assertion failed during reset");

`endif

>>> src/cdd_pkg.sv
// shared types, constants and calendar tables for the civil date converter
// no dependencies
package cdd_pkg;

    localparam int unsigned YearW = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW = 5;
    localparam int unsigned QuotW = 7;   // year / 100 is at most 99
    localparam int unsigned DoyW = 9;    // day of the March-based year
    localparam int unsigned DayNumW = 23;
    localparam int unsigned SumW = 24;
    localparam int unsigned ProdW = 27;

    localparam logic [YearW-1:0] YearMax = 14'd9999;
    localparam logic [12:0] Recip100 = 13'd5243;     // ceil(2^19 / 100)
    localparam int unsigned Recip100Shift = 19;
    localparam logic [SumW-1:0] EpochShift = 24'd719468;
    localparam logic [SumW-1:0] DaysPerYear = 24'd365;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    typedef struct packed {
        logic              ok;
        logic [YearW-1:0]  ys;    // year shifted so it starts in March
        logic [QuotW-1:0]  qs;    // ys / 100
        logic [DoyW-1:0]   doy;
    } stage_t;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
        logic [DayW-1:0] len;
        unique case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before month mp of a year that starts in March
    function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] mp);
        logic [DoyW-1:0] cum;
        unique case (mp)
            4'd0:    cum = 9'd0;
            4'd1:    cum = 9'd31;
            4'd2:    cum = 9'd61;
            4'd3:    cum = 9'd92;
            4'd4:    cum = 9'd122;
            4'd5:    cum = 9'd153;
            4'd6:    cum = 9'd184;
            4'd7:    cum = 9'd214;
            4'd8:    cum = 9'd245;
            4'd9:    cum = 9'd275;
            4'd10:   cum = 9'd306;
            4'd11:   cum = 9'd337;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

>>> src/cdd_front.sv
// first two pipeline stages: year / 100 by reciprocal, then date check and day of year
// depends on cdd_pkg
module cdd_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [cdd_pkg::YearW-1:0]   up_year,
    input  logic [cdd_pkg::MonthW-1:0]  up_month,
    input  logic [cdd_pkg::DayW-1:0]    up_day,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output cdd_pkg::stage_t             dn_data
);

    logic                        st1_valid_reg;
    logic [cdd_pkg::YearW-1:0]   st1_year_reg;
    logic [cdd_pkg::MonthW-1:0]  st1_month_reg;
    logic [cdd_pkg::DayW-1:0]    st1_day_reg;
    logic [cdd_pkg::ProdW-1:0]   st1_prod_reg;
    logic [cdd_pkg::ProdW-1:0]   st1_prod_next;

    logic                        st2_valid_reg;
    cdd_pkg::stage_t             st2_data_reg;
    cdd_pkg::stage_t             st2_data_next;

    logic ready1;
    logic ready2;

    logic [cdd_pkg::QuotW-1:0]   q100;
    logic [cdd_pkg::YearW-1:0]   rem_full;
    logic [cdd_pkg::QuotW-1:0]   rem100;
    logic                        leap;
    logic                        early;
    logic [cdd_pkg::DayW-1:0]    lim;
    logic [cdd_pkg::MonthW-1:0]  mp;
    logic                        ok;

    assign ready2 = !st2_valid_reg || dn_ready;
    assign ready1 = !st1_valid_reg || ready2;
    assign up_ready = ready1;

    assign st1_prod_next = cdd_pkg::ProdW'(up_year) * cdd_pkg::ProdW'(cdd_pkg::Recip100);

    always_comb begin
        q100 = st1_prod_reg[cdd_pkg::Recip100Shift +: cdd_pkg::QuotW];
        rem_full = st1_year_reg - cdd_pkg::YearW'(q100) * 14'd100;
        rem100 = rem_full[cdd_pkg::QuotW-1:0];
        leap = ((st1_year_reg[1:0] == 2'd0) && (rem100 != '0))
            || ((rem100 == '0) && (q100[1:0] == 2'd0));
        early = (st1_month_reg <= cdd_pkg::MonthFeb);
        lim = ((st1_month_reg == cdd_pkg::MonthFeb) && leap)
            ? 5'd29 : cdd_pkg::month_len(st1_month_reg);
        ok = (st1_year_reg != '0) && (st1_year_reg <= cdd_pkg::YearMax)
            && (st1_month_reg != '0) && (st1_month_reg <= cdd_pkg::MonthDec)
            && (st1_day_reg != '0) && (st1_day_reg <= lim);
        mp = early ? (st1_month_reg + 4'd9) : (st1_month_reg - 4'd3);
        st2_data_next.ok = ok;
        st2_data_next.ys = st1_year_reg - cdd_pkg::YearW'(early);
        // shifted year crosses a century boundary only in Jan/Feb of a round year
        st2_data_next.qs = (early && (rem100 == '0)) ? (q100 - 7'd1) : q100;
        st2_data_next.doy = cdd_pkg::days_before(mp)
            + cdd_pkg::DoyW'(st1_day_reg) - 9'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (ready1) begin
                st1_valid_reg <= up_valid;
            end
            if (ready2) begin
                st2_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && up_valid) begin
            st1_year_reg  <= up_year;
            st1_month_reg <= up_month;
            st1_day_reg   <= up_day;
            st1_prod_reg  <= st1_prod_next;
        end
        if (ready2 && st1_valid_reg) begin
            st2_data_reg <= st2_data_next;
        end
    end

    assign dn_valid = st2_valid_reg;
    assign dn_data = st2_data_reg;

endmodule

>>> src/cdd_count.sv
// last stage and output register: day count from shifted year and day of year
// depends on cdd_pkg
module cdd_count (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  cdd_pkg::stage_t               up_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_ok,
    output logic [cdd_pkg::DayNumW-1:0]   out_day_number
);

    logic                          valid_reg;
    logic                          ok_reg;
    logic [cdd_pkg::DayNumW-1:0]   day_number_reg;
    logic [cdd_pkg::DayNumW-1:0]   day_number_next;
    logic [cdd_pkg::SumW-1:0]      sum;
    logic                          ready;

    assign ready = !valid_reg || out_ready;
    assign up_ready = ready;

    // ys*365 + ys/4 - ys/100 + ys/400 + doy equals era*146097 + day of era, less the 1970-01-01 shift; 0 if invalid
    always_comb begin
        sum = cdd_pkg::SumW'(up_data.ys) * cdd_pkg::DaysPerYear
            + cdd_pkg::SumW'(up_data.ys[cdd_pkg::YearW-1:2])
            - cdd_pkg::SumW'(up_data.qs)
            + cdd_pkg::SumW'(up_data.qs[cdd_pkg::QuotW-1:2])
            + cdd_pkg::SumW'(up_data.doy)
            - cdd_pkg::EpochShift;
        day_number_next = up_data.ok ? sum[cdd_pkg::DayNumW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && up_valid) begin
            ok_reg <= up_data.ok;
            day_number_reg <= day_number_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ok = ok_reg;
    assign out_day_number = day_number_reg;

endmodule

>>> src/civil_date_to_day_number_top.sv
// Gregorian date to day number converter, top level
// depends on cdd_pkg, cdd_front, cdd_count and assert_macros.svh
//
// Use: present a date on the s_ channel (year, month, day packed in s_tdata);
// each accepted item yields exactly one result item on the m_ channel, in order.
// The result carries date_ok on m_tuser and the signed day count since 1970-01-01
// on m_tdata; invalid dates (year 0 or above 9999, bad month, day out of range)
// give date_ok 0 and a day number of 0.
// Throughput: one item per cycle while the m_ channel does not stall; the three
// register stages are the year / 100 reciprocal multiply, the date check with
// day-of-year lookup, and the final 365-day multiply and sum that loads the
// output register.
// Stalls: when m_tready is low the result holds on m_tdata, and earlier stages
// keep filling empty slots, so s_tready drops only once all stages hold items.
// Reset: aresetn low (synchronous) drops every valid bit; nothing is in flight
// afterward and m_tvalid is low.
`include "assert_macros.svh"

module civil_date_to_day_number_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // year[13:0], month[17:14], day[22:18], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // day_number[22:0], zero pad
    output logic        m_tuser     // date_ok
);

    logic                          mid_valid;
    logic                          mid_ready;
    cdd_pkg::stage_t               mid_data;
    logic                          res_ok;
    logic [cdd_pkg::DayNumW-1:0]   res_day_number;
    logic                          day_in_range;

    cdd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .up_year  (s_tdata[13:0]),
        .up_month (s_tdata[17:14]),
        .up_day   (s_tdata[22:18]),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .dn_data  (mid_data)
    );

    cdd_count u_count (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .up_valid       (mid_valid),
        .up_ready       (mid_ready),
        .up_data        (mid_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_ok         (res_ok),
        .out_day_number (res_day_number)
    );

    assign m_tdata = {1'b0, res_day_number};
    assign m_tuser = res_ok;

    assign day_in_range = ($signed(res_day_number) >= -23'sd719162)
        && ($signed(res_day_number) <= 23'sd2932896);

    `CDD_ASSERT(a_bad_date_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    `CDD_ASSERT(a_day_in_range, aclk, aresetn, (m_tvalid && m_tuser) |-> day_in_range)
    `CDD_ASSERT_ALWAYS(a_reset_empties, aclk, $past(!aresetn) |-> !m_tvalid)

endmodule
